### rtl/lmd_pkg.sv
// Shared types and constants for the message header deframer.
package lmd_pkg;

    localparam logic [31:0] HEADER_BYTES   = 32'd10;
    localparam logic [31:0] MAX_BYTES_RST  = 32'd65536;

    localparam logic [1:0]  KIND_HEADER    = 2'd0;
    localparam logic [1:0]  KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0]  KIND_ERROR     = 2'd2;

    localparam logic        ERR_SHORT      = 1'b0;
    localparam logic        ERR_LONG       = 1'b1;

    localparam logic [3:0]  CNT_LEN_START  = 4'd2;
    localparam logic [3:0]  CNT_ID_START   = 4'd6;
    localparam logic [3:0]  CNT_LAST_HDR   = 4'd9;

    localparam logic        REG_MAX_BYTES  = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first_word;
        logic [31:0] length_word;
        logic [31:0] id_word;
        logic [7:0]  data_byte;
        logic        error_code;
        logic        last;
    } t_rec;

endpackage

### rtl/lmd_front.sv
// Front part: collects header bytes, checks the length, tags payload beats.
module lmd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic [31:0]        i_max_bytes,
    input  logic               i_full,
    output logic               o_push,
    output lmd_pkg::t_rec      o_rec
);

    logic        r_in_payload, n_in_payload;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_first, n_first;
    logic [31:0] r_length, n_length;
    logic [31:0] r_id, n_id;
    logic [31:0] r_left, n_left;
    logic        accept;
    logic [31:0] id_full;
    logic [31:0] left_dec;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign id_full  = {r_id[23:0], i_byte};
    assign left_dec = r_left - 32'd1;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_first      = r_first;
        n_length     = r_length;
        n_id         = r_id;
        n_left       = r_left;
        o_push       = 1'b0;
        o_rec        = '0;
        if (accept) begin
            if (r_in_payload) begin
                n_left          = left_dec;
                n_in_payload    = (left_dec != 32'd0);
                o_push          = 1'b1;
                o_rec.kind      = lmd_pkg::KIND_PAYLOAD;
                o_rec.data_byte = i_byte;
                o_rec.last      = (left_dec == 32'd0);
            end else begin
                if (r_hdr_cnt < lmd_pkg::CNT_LEN_START) begin
                    n_first = {r_first[7:0], i_byte};
                end else if (r_hdr_cnt < lmd_pkg::CNT_ID_START) begin
                    n_length = {r_length[23:0], i_byte};
                end else begin
                    n_id = id_full;
                end
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (r_hdr_cnt == lmd_pkg::CNT_LAST_HDR) begin
                    n_hdr_cnt         = '0;
                    o_push            = 1'b1;
                    o_rec.first_word  = r_first;
                    o_rec.length_word = r_length;
                    o_rec.id_word     = id_full;
                    if (r_length < lmd_pkg::HEADER_BYTES) begin
                        o_rec.kind       = lmd_pkg::KIND_ERROR;
                        o_rec.error_code = lmd_pkg::ERR_SHORT;
                    end else if (r_length > i_max_bytes) begin
                        o_rec.kind       = lmd_pkg::KIND_ERROR;
                        o_rec.error_code = lmd_pkg::ERR_LONG;
                    end else begin
                        o_rec.kind   = lmd_pkg::KIND_HEADER;
                        n_left       = r_length - lmd_pkg::HEADER_BYTES;
                        n_in_payload = (r_length != lmd_pkg::HEADER_BYTES);
                        o_rec.last   = (r_length == lmd_pkg::HEADER_BYTES);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_length <= n_length;
        r_id     <= n_id;
        r_left   <= n_left;
    end

endmodule

### rtl/lmd_queue.sv
// Short result queue between the front and back parts.
module lmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lmd_pkg::t_rec      i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output lmd_pkg::t_rec      o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lmd_pkg::t_rec    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/lmd_back.sv
// Back part: splits queued records into result fields and holds the output beat.
module lmd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  lmd_pkg::t_rec      i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_version,
    output logic [9:0]         o_msg_type,
    output logic [2:0]         o_reserved_bits,
    output logic [31:0]        o_total_length,
    output logic [31:0]        o_msg_id,
    output logic [7:0]         o_data_byte,
    output logic               o_error_code,
    output logic               o_last
);

    logic r_valid;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_kind          <= i_rec.kind;
            o_version       <= i_rec.first_word[15:13];
            o_msg_type      <= i_rec.first_word[12:3];
            o_reserved_bits <= i_rec.first_word[2:0];
            o_total_length  <= i_rec.length_word;
            o_msg_id        <= i_rec.id_word;
            o_data_byte     <= i_rec.data_byte;
            o_error_code    <= i_rec.error_code;
            o_last          <= i_rec.last;
        end
    end

endmodule

### rtl/llrp_message_deframer_top.sv
// Top level of the message header deframer: config register, front, queue, back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | o_kind .. o_last (nine fields)
//  config  | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One byte beat is accepted per clock while the queue has room; its result is queued, then registered in the back.
// The front stalls only when the result queue (QUEUE_DEPTH entries) is full.
// The back keeps one output register; a stalled output beat holds its fields.
// Reset clears the parser state, the queue and the output valid; max length -> 65536.
module llrp_message_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_version,
    output logic [9:0]  o_msg_type,
    output logic [2:0]  o_reserved_bits,
    output logic [31:0] o_total_length,
    output logic [31:0] o_msg_id,
    output logic [7:0]  o_data_byte,
    output logic        o_error_code,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]   r_max_bytes;
    logic          q_full, q_empty, q_push, q_pop;
    lmd_pkg::t_rec push_rec, pop_rec;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lmd_pkg::REG_MAX_BYTES) ? r_max_bytes : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= lmd_pkg::MAX_BYTES_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == lmd_pkg::REG_MAX_BYTES) begin
            r_max_bytes <= pwdata;
        end
    end

    lmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_byte      (i_in_byte),
        .i_max_bytes (r_max_bytes),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_rec       (push_rec)
    );

    lmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (pop_rec)
    );

    lmd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_rec           (pop_rec),
        .o_pop           (q_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_kind          (o_kind),
        .o_version       (o_version),
        .o_msg_type      (o_msg_type),
        .o_reserved_bits (o_reserved_bits),
        .o_total_length  (o_total_length),
        .o_msg_id        (o_msg_id),
        .o_data_byte     (o_data_byte),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

endmodule

### dv/llrp_message_deframer_checker.sv
// Checker for the message deframer: follows byte and register beats, predicts results, compares.
`timescale 1ns / 100ps
module llrp_message_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_version,
    input  logic [9:0]  i_msg_type,
    input  logic [2:0]  i_reserved_bits,
    input  logic [31:0] i_total_length,
    input  logic [31:0] i_msg_id,
    input  logic [7:0]  i_data_byte,
    input  logic        i_error_code,
    input  logic        i_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam logic [2:0] MAX_BYTES_ADDR = {lmd_pkg::REG_MAX_BYTES, 2'b00};

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  version;
        logic [9:0]  msg_type;
        logic [2:0]  rsvd;
        logic [31:0] total_len;
        logic [31:0] msg_id;
        logic [7:0]  data;
        logic        err;
        logic        last;
    } t_msg_result;

    t_msg_result expected_results[$];

    logic [31:0] max_bytes;
    logic        in_payload;
    logic [3:0]  hdr_count;
    logic [15:0] first_word;
    logic [31:0] length_word;
    logic [31:0] id_word;
    logic [31:0] payload_left;

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        t_msg_result r;
        r = '0;
        if (in_payload) begin
            payload_left = payload_left - 32'd1;
            if (payload_left == 32'd0)
                in_payload = 1'b0;
            r.kind = lmd_pkg::KIND_PAYLOAD;
            r.data = b;
            r.last = (payload_left == 32'd0);
            expected_results.push_back(r);
        end else begin
            if (hdr_count < lmd_pkg::CNT_LEN_START)
                first_word = {first_word[7:0], b};
            else if (hdr_count < lmd_pkg::CNT_ID_START)
                length_word = {length_word[23:0], b};
            else
                id_word = {id_word[23:0], b};
            if (hdr_count == lmd_pkg::CNT_LAST_HDR) begin
                hdr_count = '0;
                r.version   = first_word[15:13];
                r.msg_type  = first_word[12:3];
                r.rsvd      = first_word[2:0];
                r.total_len = length_word;
                r.msg_id    = id_word;
                if (length_word < lmd_pkg::HEADER_BYTES) begin
                    r.kind = lmd_pkg::KIND_ERROR;
                    r.err  = lmd_pkg::ERR_SHORT;
                end else if (length_word > max_bytes) begin
                    r.kind = lmd_pkg::KIND_ERROR;
                    r.err  = lmd_pkg::ERR_LONG;
                end else begin
                    payload_left = length_word - lmd_pkg::HEADER_BYTES;
                    in_payload   = (payload_left != 32'd0);
                    r.kind       = lmd_pkg::KIND_HEADER;
                    r.last       = (payload_left == 32'd0);
                end
                expected_results.push_back(r);
            end else begin
                hdr_count = hdr_count + 4'd1;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_msg_result got;
        t_msg_result want;
        if (!i_rst_n) begin
            max_bytes    = lmd_pkg::MAX_BYTES_RST;
            in_payload   = 1'b0;
            hdr_count    = '0;
            first_word   = '0;
            length_word  = '0;
            id_word      = '0;
            payload_left = '0;
            expected_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                parse_byte(i_in_byte);
            if (i_psel && i_penable && i_pready && i_paddr == MAX_BYTES_ADDR) begin
                if (i_pwrite)
                    max_bytes = i_pwdata;
                else
                    compare_field("prdata", max_bytes, i_prdata);
            end
            if (i_out_valid === 1'b1 && i_out_ready) begin
                got.kind      = i_kind;
                got.version   = i_version;
                got.msg_type  = i_msg_type;
                got.rsvd      = i_reserved_bits;
                got.total_len = i_total_length;
                got.msg_id    = i_msg_id;
                got.data      = i_data_byte;
                got.err       = i_error_code;
                got.last      = i_last;
                o_checked++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no result outstanding: kind 0x%0h", got.kind);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(got.kind));
                    compare_field("version", 32'(want.version), 32'(got.version));
                    compare_field("msg_type", 32'(want.msg_type), 32'(got.msg_type));
                    compare_field("reserved_bits", 32'(want.rsvd), 32'(got.rsvd));
                    compare_field("total_length", want.total_len, got.total_len);
                    compare_field("msg_id", want.msg_id, got.msg_id);
                    compare_field("data_byte", 32'(want.data), 32'(got.data));
                    compare_field("error_code", 32'(want.err), 32'(got.err));
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### dv/llrp_message_deframer_top_tb.sv
// Testbench top for the message deframer: byte, output and register traffic plus the verdict.
`timescale 1ns / 100ps
module llrp_message_deframer_top_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 140;
    localparam int NUM_PHASES  = 7;
    localparam logic [2:0] MAX_BYTES_ADDR = {lmd_pkg::REG_MAX_BYTES, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [2:0]  o_version;
    logic [9:0]  o_msg_type;
    logic [2:0]  o_reserved_bits;
    logic [31:0] o_total_length;
    logic [31:0] o_msg_id;
    logic [7:0]  o_data_byte;
    logic        o_error_code;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          checked;
    int          bytes_sent;
    int          cycles;
    logic [31:0] max_bytes;
    bit          in_gaps;
    bit          out_gaps;
    bit          quiet;
    bit          hold_out;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    llrp_message_deframer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_version      (o_version),
        .o_msg_type     (o_msg_type),
        .o_reserved_bits(o_reserved_bits),
        .o_total_length (o_total_length),
        .o_msg_id       (o_msg_id),
        .o_data_byte    (o_data_byte),
        .o_error_code   (o_error_code),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    llrp_message_deframer_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_version      (o_version),
        .i_msg_type     (o_msg_type),
        .i_reserved_bits(o_reserved_bits),
        .i_total_length (o_total_length),
        .i_msg_id       (o_msg_id),
        .i_data_byte    (o_data_byte),
        .i_error_code   (o_error_code),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("llrp_message_deframer_top test failed");
            $finish;
        end
    end

    initial begin : out_side
        bit held;
        held        = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out && !held) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end else if (out_gaps && !quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (in_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            i_in_byte  = 8'($urandom());
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [15:0] first, input logic [31:0] len,
                               input logic [31:0] id);
        logic [79:0] hdr;
        hdr = {first, len, id};
        for (int i = 9; i >= 0; i--)
            send_byte(hdr[i*8 +: 8]);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = MAX_BYTES_ADDR;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (wr)
            max_bytes = data;
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic send_message();
        logic [31:0] len;
        int          sel;
        in_gaps  = ($urandom_range(0, 3) != 0);
        out_gaps = ($urandom_range(0, 3) != 0);
        // misaligned noise only where a stray length cannot swallow the phase
        if (max_bytes <= 32'd200 && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom()));
            return;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            len = $urandom_range(0, 9);
        end else if (sel == 1 && max_bytes != '1) begin
            len = $urandom();
            if (len <= max_bytes)
                len = '1;
        end else if (sel == 2 && max_bytes != '1) begin
            len = max_bytes + 32'd1;
        end else begin
            len = lmd_pkg::HEADER_BYTES + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 80)
                                                                       : $urandom_range(0, 12));
            if (max_bytes >= lmd_pkg::HEADER_BYTES && len > max_bytes)
                len = max_bytes;
        end
        send_header(16'($urandom()), len, $urandom());
        if (len >= lmd_pkg::HEADER_BYTES && len <= max_bytes)
            repeat (len - lmd_pkg::HEADER_BYTES) send_byte(8'($urandom()));
    endtask

    initial begin : stimulus
        logic [31:0] limits [NUM_PHASES];
        int          start;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        bytes_sent = 0;
        in_gaps    = 1'b1;
        out_gaps   = 1'b1;
        quiet      = 1'b0;
        hold_out   = 1'b0;
        max_bytes  = lmd_pkg::MAX_BYTES_RST;
        limits = '{32'd65536, 32'd10, 32'hFFFF_FFFF, 32'd0, 32'd40, 32'd9, 32'd100};
        limits[NUM_PHASES-1] = $urandom_range(10, 200);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_access(1'b0, '0);
        send_header(16'hFFFF, lmd_pkg::HEADER_BYTES, 32'hFFFF_FFFF);
        send_header(16'h0000, 32'd11, 32'h0000_0000);
        send_byte(8'hFF);
        send_header(16'hA5C3, lmd_pkg::MAX_BYTES_RST + 32'd1, 32'h1234_5678);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            apb_access(1'b1, limits[phase]);
            apb_access(1'b0, '0);
            quiet = (phase == NUM_PHASES - 1);
            if (phase == 0) begin
                hold_out = 1'b1;
                send_header(16'h2001, 32'd60, $urandom());
                repeat (50) send_byte(8'($urandom()));
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_message();
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d byte beats and checked %0d result beats across %0d length limits,",
                 bytes_sent, checked, NUM_PHASES);
        $display("with short, oversized and header-only messages, noise and a long output stall.");
        if (fail_count == 0)
            $display("llrp_message_deframer_top test passed");
        else
            $display("llrp_message_deframer_top test failed");
        $finish;
    end

endmodule
